// File: hw/rtl/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// Resistor ladder button decoder package
// Shared types, register indexes, event codes and ladder thresholds.
// ----------------------------------------------------------------------------
package rlbd_pkg;

    localparam int SAMPLE_W         = 10;
    localparam int SAMPLES_PER_ITEM = 2;
    localparam int MAX_BUTTONS      = 4;
    localparam int BTN_W            = 3;
    localparam int CNT_W            = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;
    localparam int CMP_W            = SAMPLE_W + 1;
    localparam int FIFO_ENTRIES     = 4;
    localparam int QPTR_W           = $clog2(FIFO_ENTRIES);
    localparam int FULL_SCALE       = 1023;

    // Ladder thresholds before the tolerance is taken off.
    localparam int THR_1 = FULL_SCALE / 2;
    localparam int THR_2 = FULL_SCALE / 3;
    localparam int THR_3 = FULL_SCALE / 4;
    localparam int THR_4 = FULL_SCALE / 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_EVENTS   = 3'd4;

    // Event codes.
    localparam logic [1:0] KIND_CLICK      = 2'd0;
    localparam logic [1:0] KIND_LONG_CLICK = 2'd1;
    localparam logic [1:0] KIND_PRESS      = 2'd2;
    localparam logic [1:0] KIND_LONG_PRESS = 2'd3;

    localparam logic [BTN_W-1:0] NO_BUTTON = '0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] button_number;
    } t_out_item;

    typedef struct packed {
        logic [7:0] tolerance;
        logic [7:0] debounce_limit;
        logic [7:0] long_limit;
        logic [2:0] button_count;
        logic       press_events_on;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [CMP_W-1:0] ladder_threshold(input logic [1:0] idx);
        logic [CMP_W-1:0] thr;
        case (idx)
            2'd0:    thr = CMP_W'(THR_1);
            2'd1:    thr = CMP_W'(THR_2);
            2'd2:    thr = CMP_W'(THR_3);
            2'd3:    thr = CMP_W'(THR_4);
            default: thr = '0;
        endcase
        return thr;
    endfunction

endpackage

// File: hw/rtl/resistor_ladder_button_decoder_top.sv
// ----------------------------------------------------------------------------
// Resistor ladder button decoder
// Sample pair in, click / long click / press / long press events out.
// ----------------------------------------------------------------------------
// The block takes one sample pair per clock cycle for as long as the event
// output is not stalled; an item's event, if it has one, leaves through the
// front classification register, the four-entry queue and the back output
// register in that order. The rate is set by the back end, which updates the
// held button and hold count for each item it takes. A stall on the output
// first fills the queue and only then stalls the input. Configuration writes
// are always ready; the front classifies an item when it is accepted and the
// back tracks it later, so registers should only be written while no item is
// in flight.
module resistor_ladder_button_decoder_top import rlbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    t_queue_status    q_status;
    logic             push;
    logic [BTN_W-1:0] push_btn;
    logic             pop;
    logic [BTN_W-1:0] pop_btn;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance       <= 8'd20;
            r_cfg.debounce_limit  <= 8'd4;
            r_cfg.long_limit      <= 8'd99;
            r_cfg.button_count    <= 3'd4;
            r_cfg.press_events_on <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOLERANCE:      r_cfg.tolerance       <= i_cfg_data;
                CFG_DEBOUNCE_LIMIT: r_cfg.debounce_limit  <= i_cfg_data;
                CFG_LONG_LIMIT:     r_cfg.long_limit      <= i_cfg_data;
                CFG_BUTTON_COUNT:   r_cfg.button_count    <= i_cfg_data[2:0];
                CFG_PRESS_EVENTS:   r_cfg.press_events_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rlbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_btn (push_btn)
    );

    rlbd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_btn (push_btn),
        .i_pop      (pop),
        .o_pop_btn  (pop_btn),
        .o_status   (q_status)
    );

    rlbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_btn       (pop_btn),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // The front never offers an item to a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("item pushed into a full queue");

    // The input is only stalled when the queue is full.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_status.full)
        else $error("input stalled while the queue has room");

    // Press events appear only when they are enabled.
    a_press_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.event_kind == KIND_PRESS
                      || o_out_item.event_kind == KIND_LONG_PRESS))
        |-> r_cfg.press_events_on)
        else $error("press event with press events disabled");

    // Nothing leaves the block in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("event presented straight after reset");

endmodule

// File: hw/rtl/rlbd_front.sv
// ----------------------------------------------------------------------------
// Resistor ladder button decoder front end
// Accepts sample pairs, averages them and registers the button number.
// ----------------------------------------------------------------------------
module rlbd_front import rlbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    input  t_queue_status    i_q_status,
    output logic             o_push,
    output logic [BTN_W-1:0] o_push_btn
);

    logic             r_valid;
    logic [BTN_W-1:0] r_btn;
    logic [BTN_W-1:0] n_btn;
    logic [CMP_W-1:0] sum;
    logic [SAMPLE_W-1:0] avg;
    logic [BTN_W-1:0] count;
    logic [CMP_W-1:0] level;
    logic             in_fire;

    always_comb begin
        sum = {1'b0, i_in_item.sample_first} + {1'b0, i_in_item.sample_second};
        if (SAMPLES_PER_ITEM < 2) begin
            avg = i_in_item.sample_first;
        end else begin
            avg = sum[CMP_W-1:1];
        end
        count = (i_cfg.button_count > BTN_W'(MAX_BUTTONS)) ? BTN_W'(MAX_BUTTONS)
                                                            : i_cfg.button_count;
        // avg > thr - tol is checked as avg + tol > thr, which cannot wrap.
        level = {1'b0, avg} + {{(CMP_W-8){1'b0}}, i_cfg.tolerance};
        n_btn = NO_BUTTON;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
            if (BTN_W'(i) < count && level > ladder_threshold(2'(i))) begin
                n_btn = BTN_W'(i + 1);
            end
        end
    end

    assign o_in_stall = r_valid && i_q_status.full;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_push_btn = r_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_fire) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_btn <= n_btn;
        end
    end

endmodule

// File: hw/rtl/rlbd_queue.sv
// ----------------------------------------------------------------------------
// Resistor ladder button decoder queue
// Short first-in first-out queue of button numbers between front and back.
// ----------------------------------------------------------------------------
module rlbd_queue import rlbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [BTN_W-1:0] i_push_btn,
    input  logic             i_pop,
    output logic [BTN_W-1:0] o_pop_btn,
    output t_queue_status    o_status
);

    logic [BTN_W-1:0] r_mem [FIFO_ENTRIES];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == (QPTR_W+1)'(FIFO_ENTRIES));
    assign o_status.empty = (r_count == '0);
    assign do_push   = i_push && !o_status.full;
    assign do_pop    = i_pop && !o_status.empty;
    assign o_pop_btn = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_btn;
        end
    end

endmodule

// File: hw/rtl/rlbd_back.sv
// ----------------------------------------------------------------------------
// Resistor ladder button decoder back end
// Tracks the held button and its hold count and issues click and press events.
// ----------------------------------------------------------------------------
module rlbd_back import rlbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_queue_status    i_q_status,
    input  logic [BTN_W-1:0] i_btn,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    logic [BTN_W-1:0] r_last;
    logic [CNT_W-1:0] r_hold;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [BTN_W-1:0] n_last;
    logic [CNT_W-1:0] n_hold;
    logic             emit;
    t_out_item        n_item;
    logic             take;

    function automatic logic [1:0] btn_number(input logic [BTN_W-1:0] btn);
        logic [BTN_W-1:0] idx;
        idx = btn - 1'b1;
        return idx[1:0];
    endfunction

    always_comb begin
        n_last = r_last;
        n_hold = r_hold;
        emit   = 1'b0;
        n_item.event_kind    = KIND_CLICK;
        n_item.button_number = btn_number(i_btn);
        if (i_btn != r_last) begin
            // Release or change: report the old button, then start afresh.
            n_item.button_number = btn_number(r_last);
            if (r_last != NO_BUTTON) begin
                if (r_hold >= i_cfg.long_limit) begin
                    emit = 1'b1;
                    n_item.event_kind = KIND_LONG_CLICK;
                end else if (r_hold >= i_cfg.debounce_limit) begin
                    emit = 1'b1;
                    n_item.event_kind = KIND_CLICK;
                end
            end
            n_last = i_btn;
            n_hold = '0;
        end else if (i_btn != NO_BUTTON && r_hold < i_cfg.long_limit) begin
            n_hold = r_hold + 1'b1;
            if (i_cfg.press_events_on) begin
                if (n_hold == i_cfg.long_limit) begin
                    emit = 1'b1;
                    n_item.event_kind = KIND_LONG_PRESS;
                end else if (n_hold == i_cfg.debounce_limit) begin
                    emit = 1'b1;
                    n_item.event_kind = KIND_PRESS;
                end
            end
        end
    end

    assign take        = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= NO_BUTTON;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_last      <= n_last;
                r_hold      <= n_hold;
                r_out_valid <= emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out_item <= n_item;
        end
    end

endmodule

// File: tb/resistor_ladder_button_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resistor ladder button decoder regression
// Drives sample pairs through the decoder and checks every click, long click,
// press and long press event against a cycle-free model of the button
// tracker or typed table row. A short directed table comes first, then random
// press sequences under a series of register settings, with bursty input,
// random output stalls and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module resistor_ladder_button_decoder_top_test;
    import rlbd_pkg::*;

    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 1025;
    localparam int PHASE_ITEMS     = 70;
    localparam int REPORT_LIMIT    = 100;
    localparam int ITEM_W          = $bits(t_in_item);

    // No register sits at this index; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} t_stall_mode;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        logic      fires;
        t_out_item ev;
    } t_pair_entry;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_pair_entry           entry;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  o_cfg_ready;

    resistor_ladder_button_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the registers, at their reset values.
    logic [7:0] sh_tol   = 8'd20;
    logic [7:0] sh_deb   = 8'd4;
    logic [7:0] sh_long  = 8'd99;
    logic [2:0] sh_count = 3'd4;
    logic       sh_press = 1'b0;

    // Tracker state: the button held and how long it has been held.
    logic [BTN_W-1:0] trk_button = NO_BUTTON;
    logic [CNT_W-1:0] trk_count  = '0;

    t_pair_entry pending_pairs[$];
    t_out_item   expected_events[$];
    t_dir_row    dir_tab[$];

    int fail_count  = 0;
    int n_items_in  = 0;
    int n_events    = 0;
    int n_writes    = 0;
    int n_phases    = 0;
    int kind_hits[4];

    bit hold_off_go = 1'b0;
    logic long_hold = 1'b0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic int sample_average(input t_in_item it);
        if (SAMPLES_PER_ITEM < 2)
            return int'(it.sample_first);
        return (int'(it.sample_first) + int'(it.sample_second)) / 2;
    endfunction

    // Thresholds can go negative with a large tolerance, hence the int compare.
    function automatic logic [BTN_W-1:0] ladder_button(input int avg);
        int lim;
        lim = (sh_count > MAX_BUTTONS) ? MAX_BUTTONS : int'(sh_count);
        for (int b = 1; b <= lim; b++) begin
            if (avg > FULL_SCALE / (b + 1) - int'(sh_tol))
                return BTN_W'(b);
        end
        return NO_BUTTON;
    endfunction

    function automatic t_out_item make_event(input logic [1:0] kind, input logic [BTN_W-1:0] btn);
        t_out_item e;
        e.event_kind    = kind;
        e.button_number = 2'(btn - 3'd1);
        return e;
    endfunction

    task automatic track_item(input t_in_item it, output bit fired, output t_out_item ev);
        logic [BTN_W-1:0] btn;
        btn   = ladder_button(sample_average(it));
        fired = 1'b0;
        ev    = '0;
        if (btn != trk_button) begin
            // Release or change: the old button's click is decided here.
            if (trk_button != NO_BUTTON) begin
                if (trk_count >= sh_long) begin
                    fired = 1'b1;
                    ev    = make_event(KIND_LONG_CLICK, trk_button);
                end else if (trk_count >= sh_deb) begin
                    fired = 1'b1;
                    ev    = make_event(KIND_CLICK, trk_button);
                end
            end
            trk_button = btn;
            trk_count  = '0;
        end else if (btn != NO_BUTTON && trk_count < sh_long) begin
            trk_count = trk_count + 1'b1;
            if (sh_press) begin
                if (trk_count == sh_long) begin
                    fired = 1'b1;
                    ev    = make_event(KIND_LONG_PRESS, btn);
                end else if (trk_count == sh_deb) begin
                    fired = 1'b1;
                    ev    = make_event(KIND_PRESS, btn);
                end
            end
        end
    endtask

    // Finds an average that reads as the given button, from a random start.
    function automatic int average_for(input logic [BTN_W-1:0] btn);
        int start;
        int a;
        start = $urandom_range(1023, 0);
        for (int i = 0; i < 1024; i++) begin
            a = (start + i) % 1024;
            if (ladder_button(a) == btn)
                return a;
        end
        return start;
    endfunction

    function automatic t_in_item pair_for(input int avg);
        t_in_item it;
        int sum;
        int lo;
        int hi;
        int f;
        sum = 2 * avg + ((avg < 1023) ? int'($urandom_range(1, 0)) : 0);
        lo  = (sum > 1023) ? sum - 1023 : 0;
        hi  = (sum < 1023) ? sum : 1023;
        f   = $urandom_range(hi, lo);
        it.sample_first  = SAMPLE_W'(f);
        it.sample_second = SAMPLE_W'(sum - f);
        return it;
    endfunction

    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_dir_row pair_row(input int f, input int s);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.entry.item.sample_first  = SAMPLE_W'(f);
        r.entry.item.sample_second = SAMPLE_W'(s);
        return r;
    endfunction

    function automatic t_dir_row quiet_row(input int f, input int s);
        t_dir_row r;
        r = pair_row(f, s);
        r.entry.typed = 1'b1;
        return r;
    endfunction

    function automatic t_dir_row event_row(input int f, input int s, input logic [1:0] kind,
                                           input logic [BTN_W-1:0] btn);
        t_dir_row r;
        r = quiet_row(f, s);
        r.entry.fires = 1'b1;
        r.entry.ev    = make_event(kind, btn);
        return r;
    endfunction

    task automatic queue_pair(input t_in_item it);
        t_pair_entry e;
        e      = '0;
        e.item = it;
        pending_pairs.push_back(e);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TOLERANCE:      sh_tol   = data;
            CFG_DEBOUNCE_LIMIT: sh_deb   = data;
            CFG_LONG_LIMIT:     sh_long  = data;
            CFG_BUTTON_COUNT:   sh_count = data[2:0];
            CFG_PRESS_EVENTS:   sh_press = data[0];
            default: ;
        endcase
        n_writes++;
    endtask

    // Items without an event may still be in flight, so it then waits out SETTLE_CYCLES too.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pairs.size() != 0 || i_in_valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_settings(input int ph);
        logic [7:0] tol;
        logic [7:0] deb;
        logic [7:0] lng;
        logic [2:0] cnt;
        logic       prs;
        case (ph)
            0: begin
                tol = 8'd20;  deb = 8'd4;  lng = 8'd99;  cnt = 3'd4; prs = 1'b0;
            end
            1: begin
                tol = 8'd20;  deb = 8'd3;  lng = 8'd8;   cnt = 3'd4; prs = 1'b1;
            end
            2: begin
                tol = 8'd0;   deb = 8'd0;  lng = 8'd1;   cnt = 3'd1; prs = 1'b1;
            end
            3: begin
                tol = 8'd255; deb = 8'd255; lng = 8'd255; cnt = 3'd7; prs = 1'b1;
            end
            4: begin
                tol = 8'($urandom_range(255, 0)); deb = 8'd2; lng = 8'd0; cnt = 3'd3; prs = 1'b1;
            end
            5: begin
                tol = 8'($urandom_range(255, 0)); deb = 8'd1; lng = 8'd5; cnt = 3'd0; prs = 1'b1;
            end
            default: begin
                if ($urandom_range(3, 0) == 0)
                    tol = $urandom_range(1, 0) ? 8'd255 : 8'd0;
                else
                    tol = 8'($urandom_range(255, 0));
                deb = 8'($urandom_range(10, 0));
                lng = 8'($urandom_range(16, 1));
                cnt = 3'($urandom_range(7, 0));
                prs = 1'($urandom_range(1, 0));
            end
        endcase
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_DEBOUNCE_LIMIT, deb);
        write_reg(CFG_LONG_LIMIT, lng);
        write_reg(CFG_BUTTON_COUNT, {5'($urandom_range(31, 0)), cnt});
        write_reg(CFG_PRESS_EVENTS, {7'($urandom_range(127, 0)), prs});
        n_phases++;
    endtask

    // Mostly whole press-and-release sequences; some noise and cut-short holds.
    task automatic gen_phase(input int target, output int made);
        int eff;
        int sel;
        int len;
        int gaps;
        int lo;
        logic [BTN_W-1:0] btn;
        bit first;
        made  = 0;
        first = 1'b1;
        eff   = (sh_count > MAX_BUTTONS) ? MAX_BUTTONS : int'(sh_count);
        while (made < target) begin
            sel = $urandom_range(9, 0);
            if (!first && sel < 2) begin
                queue_pair(t_in_item'(ITEM_W'($urandom())));
                made++;
            end else begin
                btn = (eff == 0) ? NO_BUTTON : BTN_W'($urandom_range(eff, 1));
                if (first) begin
                    // Long enough to saturate the counter under this setting.
                    len = int'(sh_long) + 2;
                end else if (sel == 2) begin
                    btn = BTN_W'($urandom_range(eff, 0));
                    len = $urandom_range(2, 1);
                end else begin
                    case ($urandom_range(3, 0))
                        0: begin
                            lo  = (sh_deb > 0) ? int'(sh_deb) - 1 : 0;
                            len = $urandom_range(int'(sh_deb) + 2, lo + 1);
                        end
                        1: begin
                            lo  = (sh_long > 0) ? int'(sh_long) : 1;
                            len = $urandom_range(int'(sh_long) + 3, lo);
                        end
                        2: len = $urandom_range(10, 1);
                        default: len = $urandom_range(int'(sh_long) + 3, 1);
                    endcase
                end
                first = 1'b0;
                if (len > 300)
                    len = 300;
                for (int i = 0; i < len; i++)
                    queue_pair(pair_for(average_for(btn)));
                made += len;
                gaps = $urandom_range(3, 0);
                for (int i = 0; i < gaps; i++)
                    queue_pair(pair_for(average_for(NO_BUTTON)));
                made += gaps;
            end
        end
    endtask

    // Sender: bursts of random length with random gaps between them.
    t_pair_entry cur_pair;
    bit          pred_fired;
    t_out_item   pred_event;
    int          burst_left;
    int          gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_item(cur_pair.item, pred_fired, pred_event);
                if (cur_pair.typed) begin
                    if (cur_pair.fires)
                        expected_events.push_back(cur_pair.ev);
                end else if (pred_fired) begin
                    expected_events.push_back(pred_event);
                end
                n_items_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    cur_pair = pending_pairs.pop_front();
                    i_in_item  <= cur_pair.item;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(3, 0) == 0) begin
                        burst_left = $urandom_range(60, 20);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(7, 0);
                        gap_left   = $urandom_range(6, 1);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern whose mode is drawn anew at random each time mode_age runs out.
    t_stall_mode stall_mode;
    int          mode_age;
    logic        stall_now;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode = STALL_NONE;
            mode_age   = 0;
        end else begin
            mode_age++;
            if (mode_age >= 100) begin
                mode_age   = 0;
                stall_mode = t_stall_mode'($urandom_range(3, 0));
            end
            case (stall_mode)
                STALL_NONE:  stall_now = 1'b0;
                STALL_LIGHT: stall_now = ($urandom_range(3, 0) == 0);
                STALL_HEAVY: stall_now = ($urandom_range(3, 0) != 0);
                default:     stall_now = ((mode_age % 5) < 2);
            endcase
            i_out_stall <= long_hold || stall_now;
        end
    end

    initial begin
        wait (hold_off_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    t_out_item want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event kind %0d button %0d with nothing pending",
                                          o_out_item.event_kind, o_out_item.button_number));
            end else begin
                want = expected_events.pop_front();
                if (o_out_item.event_kind != want.event_kind)
                    report_mismatch($sformatf("event kind %0d, wanted %0d",
                                              o_out_item.event_kind, want.event_kind));
                if (o_out_item.button_number != want.button_number)
                    report_mismatch($sformatf("button number %0d, wanted %0d",
                                              o_out_item.button_number, want.button_number));
            end
            n_events++;
            kind_hits[o_out_item.event_kind]++;
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    int random_made;
    int phase_made;
    int ph;

    initial begin
        foreach (kind_hits[k])
            kind_hits[k] = 0;

        // Reset values first, then small limits with press events, then the
        // corner settings: zero limits, negative thresholds, odd button counts.
        dir_tab.push_back(quiet_row(0, 0));
        dir_tab.push_back(quiet_row(1023, 1023));
        dir_tab.push_back(pair_row(0, 1023));
        dir_tab.push_back(quiet_row(0, 0));
        dir_tab.push_back(reg_row(CFG_DEBOUNCE_LIMIT, 8'd2));
        dir_tab.push_back(reg_row(CFG_LONG_LIMIT, 8'd4));
        dir_tab.push_back(reg_row(CFG_PRESS_EVENTS, 8'd1));
        dir_tab.push_back(pair_row(400, 400));
        dir_tab.push_back(pair_row(400, 401));
        dir_tab.push_back(pair_row(491, 492));
        dir_tab.push_back(pair_row(330, 330));
        dir_tab.push_back(pair_row(450, 440));
        dir_tab.push_back(pair_row(400, 400));
        dir_tab.push_back(pair_row(300, 300));
        dir_tab.push_back(pair_row(300, 301));
        dir_tab.push_back(pair_row(321, 240));
        dir_tab.push_back(pair_row(0, 0));
        dir_tab.push_back(reg_row(CFG_LONG_LIMIT, 8'd0));
        dir_tab.push_back(reg_row(CFG_DEBOUNCE_LIMIT, 8'd0));
        dir_tab.push_back(reg_row(CFG_UNUSED, 8'hA5));
        dir_tab.push_back(pair_row(200, 200));
        dir_tab.push_back(pair_row(200, 201));
        dir_tab.push_back(event_row(0, 0, KIND_LONG_CLICK, 3'd4));
        dir_tab.push_back(reg_row(CFG_TOLERANCE, 8'd255));
        dir_tab.push_back(reg_row(CFG_LONG_LIMIT, 8'd3));
        dir_tab.push_back(reg_row(CFG_BUTTON_COUNT, 8'hFF));
        dir_tab.push_back(pair_row(0, 0));
        dir_tab.push_back(pair_row(0, 1));
        dir_tab.push_back(event_row(1023, 1023, KIND_CLICK, 3'd4));
        dir_tab.push_back(reg_row(CFG_BUTTON_COUNT, 8'd0));
        dir_tab.push_back(event_row(1023, 1023, KIND_CLICK, 3'd1));
        dir_tab.push_back(quiet_row(1023, 1023));
        dir_tab.push_back(reg_row(CFG_TOLERANCE, 8'd0));
        dir_tab.push_back(reg_row(CFG_BUTTON_COUNT, 8'd1));
        dir_tab.push_back(reg_row(CFG_DEBOUNCE_LIMIT, 8'd255));
        dir_tab.push_back(reg_row(CFG_LONG_LIMIT, 8'd255));
        dir_tab.push_back(quiet_row(1023, 0));
        dir_tab.push_back(pair_row(1023, 1));
        dir_tab.push_back(quiet_row(0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                pending_pairs.push_back(dir_tab[i].entry);
            end
        end
        wait_drained();

        random_made = 0;
        ph = 0;
        while (random_made < RANDOM_ITEMS) begin
            pick_settings(ph);
            gen_phase(PHASE_ITEMS, phase_made);
            if (ph == 1)
                hold_off_go = 1'b1;
            random_made += phase_made;
            wait_drained();
            ph++;
        end

        $display("Ran %0d sample pairs and checked %0d events over %0d register settings, %0d writes.",
                 n_items_in, n_events, n_phases, n_writes);
        $display("Events by kind: %0d click, %0d long click, %0d press, %0d long press.",
                 kind_hits[KIND_CLICK], kind_hits[KIND_LONG_CLICK],
                 kind_hits[KIND_PRESS], kind_hits[KIND_LONG_PRESS]);
        if (fail_count == 0 && expected_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rlbd_pkg.sv
hw/rtl/rlbd_front.sv
hw/rtl/rlbd_queue.sv
hw/rtl/rlbd_back.sv
hw/rtl/resistor_ladder_button_decoder_top.sv
tb/resistor_ladder_button_decoder_top_test.sv
